@@ design/lruo_pkg.sv @@
// shared constants, command codes and controller/datapath signal groups
package lruo_pkg;

  localparam int CMD_W    = 3;
  localparam int SLOT_F_W = 5;
  localparam int LIM_W    = 6;
  localparam int OCC_W    = 6;
  localparam int RES_W    = 6;

  localparam int MAX_RESULTS = 32;
  localparam logic [LIM_W-1:0] LIMIT_RESET = 6'd32;

  localparam logic [CMD_W-1:0] CMD_ADD    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_TOUCH  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_PEEK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_PURGE  = 3'd4;

  typedef struct packed {
    logic in_rdy;
    logic rd;
    logic sel_head;
    logic unlink;
    logic append;
    logic out_load;
    logic out_evict;
  } ctl_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             slot_ok;
    logic             slot_present;
    logic             more;
    logic             out_free;
    logic             in_fire;
  } ctl_sts_t;

endpackage

@@ design/lruo_ifs.sv @@
// valid/ready channel interfaces for command, result and limit words
interface lruo_in_if import lruo_pkg::*; ;
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [SLOT_F_W-1:0] slot;
  logic [LIM_W-1:0]    reserve;
  modport source (output valid, output cmd, output slot, output reserve, input ready);
  modport sink (input valid, input cmd, input slot, input reserve, output ready);
endinterface

interface lruo_out_if import lruo_pkg::*; ;
  logic                valid;
  logic                ready;
  logic [SLOT_F_W-1:0] victim_slot;
  logic                victim_valid;
  logic [OCC_W-1:0]    occupancy;
  logic                last;
  modport source (output valid, output victim_slot, output victim_valid, output occupancy,
                  output last, input ready);
  modport sink (input valid, input victim_slot, input victim_valid, input occupancy,
                input last, output ready);
endinterface

interface lruo_cfg_if import lruo_pkg::*; ;
  logic             valid;
  logic             ready;
  logic [LIM_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ design/lruo_ctrl.sv @@
// command sequencer for the lru order list
module lruo_ctrl import lruo_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  ctl_sts_t sts,
  output ctl_cmd_t ctl
);

  typedef enum logic [2:0] {
    S_IDLE, S_DISP, S_RD, S_UNL, S_APP, S_RESP, S_EMIT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    ctl = '0;
    unique case (state_r)
      S_IDLE: begin
        ctl.in_rdy = 1'b1;
        if (sts.in_fire) state_nxt = S_DISP;
      end
      S_DISP: begin
        unique case (sts.cmd)
          CMD_ADD: state_nxt = (sts.slot_ok && !sts.slot_present) ? S_APP : S_RESP;
          CMD_REMOVE: state_nxt = sts.slot_present ? S_RD : S_RESP;
          CMD_TOUCH: begin
            if (!sts.slot_ok) state_nxt = S_RESP;
            else state_nxt = sts.slot_present ? S_RD : S_APP;
          end
          CMD_PURGE: state_nxt = sts.more ? S_RD : S_RESP;
          default: state_nxt = S_RESP;
        endcase
      end
      S_RD: begin
        ctl.rd = 1'b1;
        ctl.sel_head = (sts.cmd == CMD_PURGE);
        state_nxt = S_UNL;
      end
      S_UNL: begin
        ctl.unlink = 1'b1;
        if (sts.cmd == CMD_TOUCH) state_nxt = S_APP;
        else if (sts.cmd == CMD_PURGE) state_nxt = S_EMIT;
        else state_nxt = S_RESP;
      end
      S_APP: begin
        ctl.append = 1'b1;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          ctl.out_evict = 1'b1;
          state_nxt = sts.more ? S_RD : S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

endmodule

@@ design/lruo_dpath.sv @@
// link memories, head/tail/count registers, purge test and result register
module lruo_dpath import lruo_pkg::*; #(
  parameter int SLOTS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  lruo_in_if.sink    in_ch,
  lruo_out_if.source out_ch,
  lruo_cfg_if.sink   cfg_ch,
  input  ctl_cmd_t   ctl,
  output ctl_sts_t   sts
);

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);

  logic [SLOT_W-1:0] next_mem [SLOTS];
  logic [SLOT_W-1:0] prev_mem [SLOTS];

  logic [LIM_W-1:0]    view_limit_r;
  logic [CMD_W-1:0]    cmd_r;
  logic [SLOT_F_W-1:0] slot_r;
  logic [LIM_W-1:0]    reserve_r;
  logic [RES_W-1:0]    n_r;
  logic [SLOTS-1:0]    present_r, present_nxt;
  logic [SLOT_W-1:0]   head_r, head_nxt, tail_r, tail_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [SLOT_W-1:0]   tgt_r, nx_q, pv_q;

  logic                out_valid_r;
  logic [SLOT_F_W-1:0] victim_slot_r;
  logic                victim_valid_r;
  logic [OCC_W-1:0]    occupancy_r;
  logic                last_r;

  logic [SLOT_W-1:0] slot_idx, rd_addr;
  logic              next_we, prev_we;
  logic [SLOT_W-1:0] next_wa, next_wd, prev_wa, prev_wd;
  logic signed [7:0] lim_s, count_s;
  logic              in_fire, more, out_free;

  assign slot_idx = SLOT_W'(slot_r);
  assign rd_addr  = ctl.sel_head ? head_r : slot_idx;

  assign in_ch.ready  = ctl.in_rdy;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign lim_s   = $signed({2'b00, view_limit_r}) - $signed({2'b00, reserve_r});
  assign count_s = $signed(8'(count_r));
  assign more    = (n_r < RES_W'(MAX_RESULTS)) && (count_r != '0) && (count_s > lim_s);
  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    sts.cmd          = cmd_r;
    sts.slot_ok      = {2'b00, slot_r} < 7'(SLOTS);
    sts.slot_present = sts.slot_ok && present_r[slot_idx];
    sts.more         = more;
    sts.out_free     = out_free;
    sts.in_fire      = in_fire;
  end

  // unlink and append each need at most one write per link memory
  always_comb begin
    next_we = 1'b0;
    next_wa = tail_r;
    next_wd = slot_idx;
    prev_we = 1'b0;
    prev_wa = slot_idx;
    prev_wd = tail_r;
    head_nxt = head_r;
    tail_nxt = tail_r;
    count_nxt = count_r;
    present_nxt = present_r;
    if (ctl.unlink) begin
      if (tgt_r == head_r) head_nxt = nx_q;
      else begin
        next_we = 1'b1;
        next_wa = pv_q;
        next_wd = nx_q;
      end
      if (tgt_r == tail_r) tail_nxt = pv_q;
      else begin
        prev_we = 1'b1;
        prev_wa = nx_q;
        prev_wd = pv_q;
      end
      present_nxt[tgt_r] = 1'b0;
      if (count_r != '0) count_nxt = count_r - CNT_W'(1);
      if (count_nxt == '0) begin
        head_nxt = '0;
        tail_nxt = '0;
      end
    end else if (ctl.append) begin
      if (count_r == '0) head_nxt = slot_idx;
      else next_we = 1'b1;
      prev_we = 1'b1;
      tail_nxt = slot_idx;
      present_nxt[slot_idx] = 1'b1;
      count_nxt = count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    if (ctl.rd) begin
      nx_q  <= next_mem[rd_addr];
      pv_q  <= prev_mem[rd_addr];
      tgt_r <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r     <= in_ch.cmd;
      slot_r    <= in_ch.slot;
      reserve_r <= in_ch.reserve;
    end
    if (ctl.out_load) begin
      occupancy_r <= OCC_W'(count_r);
      if (ctl.out_evict) begin
        victim_slot_r  <= SLOT_F_W'(tgt_r);
        victim_valid_r <= 1'b1;
        last_r         <= !more;
      end else if (cmd_r == CMD_PEEK && count_r != '0) begin
        victim_slot_r  <= SLOT_F_W'(head_r);
        victim_valid_r <= 1'b1;
        last_r         <= 1'b1;
      end else begin
        victim_slot_r  <= '0;
        victim_valid_r <= 1'b0;
        last_r         <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      view_limit_r <= LIMIT_RESET;
      present_r    <= '0;
      head_r       <= '0;
      tail_r       <= '0;
      count_r      <= '0;
      n_r          <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) view_limit_r <= cfg_ch.data;
      present_r <= present_nxt;
      head_r    <= head_nxt;
      tail_r    <= tail_nxt;
      count_r   <= count_nxt;
      if (in_fire) n_r <= '0;
      else if (ctl.unlink) n_r <= n_r + RES_W'(1);
      if (ctl.out_load) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.victim_slot  = victim_slot_r;
  assign out_ch.victim_valid = victim_valid_r;
  assign out_ch.occupancy    = occupancy_r;
  assign out_ch.last         = last_r;

  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(present_r) == int'(count_r))
    else $error("occupancy count differs from present bits");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(count_r) <= SLOTS)
    else $error("occupancy count above slot total");

  a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == '0 |-> head_r == '0 && tail_r == '0)
    else $error("empty list with nonzero head or tail");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.out_load |-> out_free)
    else $error("result word loaded over a pending word");

endmodule

@@ design/lru_order_tracker_with_purge_unit.sv @@
// top level of the lru order tracker with purge
// Keeps the use order of SLOTS cache slots as a doubly linked list, oldest
// at the head, with links held in two single-port memories and a sequencer
// that does one link read or one link update per cycle. One command word is
// worked at a time. After dispatch, peek, spare codes and commands that
// change nothing go straight to the result word; add and touch of an absent
// slot append, remove reads and unlinks, and touch of a present slot reads,
// unlinks and appends. The result word is loaded once the result side is
// ready, then the next command word is accepted from idle. Purge with nothing
// to evict gives one result word with no victim; otherwise it tests the
// limit, then reads, unlinks and emits each evicted slot, one result word per
// eviction and at most 32 per command. Each word waits on a stalled result side.
// The limit register may be written at any time the block holds no command.
module lru_order_tracker_with_purge_unit import lruo_pkg::*; #(
  parameter int SLOTS = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  lruo_in_if.sink    in_ch,
  lruo_out_if.source out_ch,
  lruo_cfg_if.sink   cfg_ch
);

  ctl_cmd_t ctl;
  ctl_sts_t sts;

  lruo_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .ctl   (ctl)
  );

  lruo_dpath #(
    .SLOTS (SLOTS)
  ) u_dpath (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch),
    .ctl    (ctl),
    .sts    (sts)
  );

endmodule
